[sv/brute_force_knn_euclidean_defines.svh]
// ----------------------------------------------------------------------------
// brute_force_knn_euclidean_defines
// assertion macros for the knn block
// ----------------------------------------------------------------------------
`ifndef BRUTE_FORCE_KNN_EUCLIDEAN_DEFINES_SVH
`define BRUTE_FORCE_KNN_EUCLIDEAN_DEFINES_SVH
`ifndef SYNTHESIS
`define KNN_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("knn check failed");
`define KNN_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("knn check failed");
`else
`define KNN_ASSERT_IMP(label, ante, cons)
`define KNN_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[sv/knn_pkg.sv]
// ----------------------------------------------------------------------------
// knn_pkg
// shared constants and types of the nearest neighbour block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package knn_pkg;
	localparam int MAX_DIMENSION = 1024;
	localparam int MAX_NEIGHBORS = 16;
	localparam int POS_W = $clog2(MAX_DIMENSION + 2);
	localparam int ADDR_W = $clog2(MAX_DIMENSION);
	localparam int NB_W = $clog2(MAX_NEIGHBORS + 1);
	localparam int IDX_W = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
	localparam int ACC_W = 27;
	localparam int DIST_W = 21;
	localparam int RANK_W = 4;
	localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
	localparam int RAD_W = ACC_W + 16;
	localparam int ROOT_W = 22;

	typedef enum logic [1:0] {
		OP_QUERY = 2'd0,
		OP_POINT = 2'd1,
		OP_READ = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ELEM,
		ST_INSERT,
		ST_ROOT,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic [ACC_W-1:0] sum;
	} root_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [ROOT_W-1:0] root;
	} root_rsp_t;
endpackage

[sv/knn_sqrt.sv]
// ----------------------------------------------------------------------------
// knn_sqrt
// bit-serial integer square root of sum * 65536, one result bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module knn_sqrt
	import knn_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input root_req_t req,
	output root_rsp_t rsp
);
	localparam int STEP_W = $clog2(ROOT_W + 1);

	logic [RAD_W-1:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [STEP_W-1:0] step_q;
	logic busy_q, done_q;
	logic [RAD_W+1:0] rem_w, trial;
	logic [ACC_W-1:0] sum_q;
	logic [1:0] pair_r;

	// two radicand bits shifted in per step, low 16 are zero
	always_comb begin
		int sh;
		sh = 2 * (ROOT_W - 1 - int'(step_q)) - 16;
		if (sh >= 0 && sh < ACC_W)
			pair_r = 2'(sum_q >> sh);
		else
			pair_r = 2'b00;
		rem_w = {rem_q, pair_r};
		trial = {(RAD_W+2-ROOT_W-2)'(0), root_q, 2'b01};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (32'(step_q) == ROOT_W - 1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			sum_q <= req.sum;
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			if (rem_w >= trial) begin
				rem_q <= RAD_W'(rem_w - trial);
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q <= RAD_W'(rem_w);
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.root = root_q;
endmodule

[sv/brute_force_knn_euclidean.sv]
// ----------------------------------------------------------------------------
// brute_force_knn_euclidean
// Nearest neighbour search over byte vectors with Euclidean distance. A query
// is loaded one byte per word (op 0), dataset points are streamed one byte per
// word (op 1), and a read (op 2) returns the kept distances in ascending order
// as square roots with 8 fraction bits, then clears the list. The block takes
// one word at a time and stalls its input until that word is finished. In the
// accept cycle of an op 0 or op 1 word the query byte is written or read; in
// the next, an op 1 word squares and adds the difference in the multiply-add
// unit. When the last word of a matching point enters the list, a sorted
// insertion follows at one kept entry a cycle. A read computes each result in
// the bit-serial square root and then hands the word over, holding it while
// the receiver stalls; a read of an empty list hands its single word over in
// the cycle after accept. Op 3 changes nothing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "brute_force_knn_euclidean_defines.svh"
module brute_force_knn_euclidean
	import knn_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] op,
	input logic [7:0] value,
	input logic last,
	output logic out_valid,
	input logic out_stall,
	output logic [DIST_W-1:0] distance,
	output logic [RANK_W-1:0] rank,
	output logic valid_res,
	output logic final_result,
	input logic cfg_we,
	input logic [4:0] cfg_wdata
);
	state_t state_q, state_d;
	logic [4:0] wanted_q;
	logic [ADDR_W-1:0] qaddr;
	logic [7:0] qmem [MAX_DIMENSION];
	logic [7:0] qbyte_q;
	logic [POS_W-1:0] pos_q, qlen_q;
	logic [ACC_W-1:0] acc_q;
	logic mis_q;
	logic [ACC_W-1:0] kept_q [MAX_NEIGHBORS];
	logic [NB_W-1:0] count_q, lim, n_eff, idx_q;
	logic [ACC_W-1:0] new_q;
	logic [7:0] val_q;
	logic last_q;
	logic op_pt_q;
	logic accept;
	root_req_t rreq;
	root_rsp_t rrsp;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		if (wanted_q == '0) lim = NB_W'(1);
		else if (32'(wanted_q) > MAX_NEIGHBORS) lim = NB_W'(MAX_NEIGHBORS);
		else lim = NB_W'(wanted_q);
		n_eff = (count_q < lim) ? count_q : lim;
	end

	assign qaddr = pos_q[ADDR_W-1:0];

	always_ff @(posedge clk) begin
		if (accept && op == OP_QUERY && 32'(pos_q) < MAX_DIMENSION)
			qmem[qaddr] <= value;
		qbyte_q <= qmem[qaddr];
	end

	// multiply-add unit for dataset points
	logic [7:0] diff;
	logic [15:0] sq;
	logic [ACC_W:0] acc_sum;
	assign diff = (val_q > qbyte_q) ? val_q - qbyte_q : qbyte_q - val_q;
	assign sq = diff * diff;
	assign acc_sum = {1'b0, acc_q} + (ACC_W+1)'(sq);

	logic inrange;
	assign inrange = (pos_q < qlen_q) && (32'(pos_q) < MAX_DIMENSION);

	logic ins_ok;
	logic [ACC_W-1:0] acc_next;
	always_comb begin
		acc_next = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
		if (!inrange) acc_next = acc_q;
		ins_ok = !(mis_q || !inrange) && (pos_q + 1'b1 == qlen_q);
	end

	// a full list only takes a sum below its largest entry
	logic ins_go;
	assign ins_go = op_pt_q && last_q && ins_ok &&
		(n_eff != lim || acc_next < kept_q[IDX_W'(lim - 1'b1)]);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (op == OP_QUERY || op == OP_POINT) state_d = ST_ELEM;
					else if (op == OP_READ) state_d = (n_eff == '0) ? ST_OUT : ST_ROOT;
				end
			end
			ST_ELEM: begin
				if (ins_go) state_d = ST_INSERT;
				else state_d = ST_IDLE;
			end
			ST_INSERT: begin
				if (idx_q == '0 || kept_q[IDX_W'(idx_q - 1'b1)] <= new_q)
					state_d = ST_IDLE;
			end
			ST_ROOT: if (rrsp.done) state_d = ST_OUT;
			ST_OUT: begin
				if (!out_stall) state_d = final_result ? ST_IDLE : ST_ROOT;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		rreq.start = 1'b0;
		rreq.sum = kept_q[IDX_W'(idx_q)];
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				rreq.start = accept && op == OP_READ && n_eff != '0;
				rreq.sum = kept_q[0];
			end
			ST_OUT: begin
				out_valid = 1'b1;
				rreq.start = !out_stall && !final_result;
				rreq.sum = kept_q[IDX_W'(idx_q + 1'b1)];
			end
			default: ;
		endcase
	end

	logic [NB_W-1:0] rd_n_q;
	logic empty_q;
	logic [DIST_W-1:0] dist_q;
	assign distance = empty_q ? '0 : dist_q;
	assign rank = RANK_W'(idx_q);
	assign valid_res = !empty_q;
	assign final_result = empty_q || (idx_q + 1'b1 == rd_n_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wanted_q <= 5'd1;
			pos_q <= '0;
			qlen_q <= '0;
			acc_q <= '0;
			mis_q <= 1'b0;
			count_q <= '0;
			idx_q <= '0;
			empty_q <= 1'b0;
			rd_n_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) wanted_q <= cfg_wdata;
			case (state_q)
				ST_IDLE: begin
					if (accept && op == OP_READ) begin
						rd_n_q <= n_eff;
						empty_q <= (n_eff == '0);
						idx_q <= '0;
						count_q <= '0;
					end
				end
				ST_ELEM: begin
					if (32'(pos_q) <= MAX_DIMENSION) pos_q <= pos_q + 1'b1;
					if (op_pt_q) begin
						acc_q <= acc_next;
						if (!inrange) mis_q <= 1'b1;
					end
					if (last_q) begin
						pos_q <= '0;
						acc_q <= '0;
						mis_q <= 1'b0;
						if (!op_pt_q)
							qlen_q <= (32'(pos_q) < MAX_DIMENSION) ? pos_q + 1'b1 : '0;
						if (op_pt_q && ins_ok) begin
							if (n_eff == lim) begin
								if (acc_next < kept_q[IDX_W'(lim - 1'b1)]) begin
									idx_q <= lim - 1'b1;
									count_q <= lim;
								end else begin
									idx_q <= '0;
									count_q <= n_eff;
								end
							end else begin
								idx_q <= n_eff;
								count_q <= n_eff + 1'b1;
							end
						end
					end
				end
				ST_INSERT: begin
					if (!(idx_q == '0 || kept_q[IDX_W'(idx_q - 1'b1)] <= new_q))
						idx_q <= idx_q - 1'b1;
				end
				ST_OUT: if (!out_stall && !final_result) idx_q <= idx_q + 1'b1;
				default: ;
			endcase
		end
	end

	// insertion shifts one entry a cycle; a full list with a sum not below its largest entry skips
	always_ff @(posedge clk) begin
		if (accept) begin
			val_q <= value;
			last_q <= last;
			op_pt_q <= (op == OP_POINT);
		end
		if (state_q == ST_ELEM) new_q <= acc_next;
		if (state_q == ST_INSERT) begin
			if (idx_q == '0 || kept_q[IDX_W'(idx_q - 1'b1)] <= new_q)
				kept_q[IDX_W'(idx_q)] <= new_q;
			else
				kept_q[IDX_W'(idx_q)] <= kept_q[IDX_W'(idx_q - 1'b1)];
		end
		if (rrsp.done)
			dist_q <= (rrsp.root > ROOT_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(rrsp.root);
	end

	knn_sqrt u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.req(rreq),
		.rsp(rrsp)
	);

	`KNN_ASSERT_IMP(a_out_only_in_out, out_valid, state_q == ST_OUT)
	`KNN_ASSERT_IMP(a_count_bound, 1'b1, count_q <= NB_W'(MAX_NEIGHBORS))
	`KNN_ASSERT_NEXT(a_root_done, state_q == ST_ROOT && rrsp.done, state_q == ST_OUT)
endmodule

[test/tb_brute_force_knn_euclidean.sv]
// ----------------------------------------------------------------------------
// tb_brute_force_knn_euclidean
// drives query loads, dataset vectors, reads, no-op words and limit writes into the nearest neighbour
// block, predicts the sorted distances and checks every result word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_brute_force_knn_euclidean
	import knn_pkg::*;
();

	localparam int CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic [RANK_W-1:0] rank;
		logic valid_res;
		logic final_result;
	} knn_res_t;

	typedef struct {
		op_t op;
		logic [7:0] value;
		logic last;
		logic typed;
		knn_res_t res;
	} stim_row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [1:0] op = 0;
	logic [7:0] value = 0;
	logic last = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [DIST_W-1:0] distance;
	logic [RANK_W-1:0] rank;
	logic valid_res;
	logic final_result;
	logic cfg_we = 0;
	logic [4:0] cfg_wdata = 0;

	brute_force_knn_euclidean DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .value(value), .last(last),
		.out_valid(out_valid), .out_stall(out_stall),
		.distance(distance), .rank(rank), .valid_res(valid_res),
		.final_result(final_result),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [7:0] q_bytes [MAX_DIMENSION];
	int unsigned q_len, pos, acc, kept_n, want;
	bit mismatch;
	int unsigned kept [MAX_NEIGHBORS];

	knn_res_t expected_words[$];
	int errors = 0;
	bit quiet = 0;
	bit hold_long = 0;
	longint cycles = 0;
	int stall_left = 0;

	function automatic int unsigned knn_limit();
		if (want < 1) return 1;
		if (want > MAX_NEIGHBORS) return MAX_NEIGHBORS;
		return want;
	endfunction

	function automatic logic [DIST_W-1:0] root_q8(int unsigned s);
		longint unsigned x, r;
		x = longint'(s) << 16;
		r = 0;
		for (int b = 21; b >= 0; b--)
			if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= x) r |= 64'd1 << b;
		return (r > DIST_MAX) ? DIST_MAX : r[DIST_W-1:0];
	endfunction

	task automatic keep_sum(int unsigned s);
		int unsigned lim, n, i;
		lim = knn_limit();
		n = (kept_n < lim) ? kept_n : lim;
		if (n == lim) begin
			if (s >= kept[lim-1]) begin
				kept_n = n;
				return;
			end
			n = lim - 1;
		end
		i = n;
		while (i > 0 && kept[i-1] > s) begin
			kept[i] = kept[i-1];
			i--;
		end
		kept[i] = s;
		kept_n = n + 1;
	endtask

	task automatic predict_word(op_t o, logic [7:0] v, logic l);
		int unsigned d, a, lim, n;
		knn_res_t r;
		case (o)
			OP_QUERY: begin
				if (pos < MAX_DIMENSION) q_bytes[pos] = v;
				if (pos <= MAX_DIMENSION) pos++;
				if (l) begin
					q_len = (pos - 1 < MAX_DIMENSION) ? pos : 0;
					pos = 0; acc = 0; mismatch = 0;
				end
			end
			OP_POINT: begin
				if (pos < q_len && pos < MAX_DIMENSION) begin
					d = (v > q_bytes[pos]) ? v - q_bytes[pos] : q_bytes[pos] - v;
					a = acc + d * d;
					acc = (a > ACC_MAX) ? ACC_MAX : a;
				end else begin
					mismatch = 1;
				end
				if (pos <= MAX_DIMENSION) pos++;
				if (l) begin
					if (!mismatch && pos == q_len) keep_sum(acc);
					pos = 0; acc = 0; mismatch = 0;
				end
			end
			OP_READ: begin
				lim = knn_limit();
				n = (kept_n < lim) ? kept_n : lim;
				kept_n = 0;
				if (n == 0) begin
					r = '{distance: 0, rank: 0, valid_res: 0, final_result: 1};
					expected_words = {expected_words, r};
				end
				for (int k = 0; k < n; k++) begin
					r.distance = root_q8(kept[k]);
					r.rank = k[RANK_W-1:0];
					r.valid_res = 1;
					r.final_result = (k + 1 == n);
					expected_words = {expected_words, r};
				end
			end
			default: ;
		endcase
	endtask

	task automatic send_word(op_t o, logic [7:0] v, logic l);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1;
		op <= o;
		value <= v;
		last <= l;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_word(o, v, l);
	endtask

	task automatic go_idle();
		in_valid <= 0;
		@(posedge clk);
		while (expected_words.size() != 0) @(posedge clk);
		// a kept point may still be in its insertion pass
		repeat (60) @(posedge clk);
	endtask

	task automatic write_limit(logic [4:0] n);
		cfg_we <= 1;
		cfg_wdata <= n;
		@(posedge clk);
		cfg_we <= 0;
		want = n;
	endtask

	task automatic send_query(int unsigned len, bit extreme);
		for (int i = 0; i < len; i++)
			send_word(OP_QUERY, extreme ? ((i % 2) ? 8'hff : 8'h00) : 8'($urandom),
				i == len - 1);
	endtask

	task automatic send_point(int unsigned len);
		for (int i = 0; i < len; i++)
			send_word(OP_POINT, 8'($urandom), i == len - 1);
	endtask

	// result checking
	always @(posedge clk) begin
		knn_res_t got, exp_w;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_brute_force_knn_euclidean NOT OK");
			$finish;
		end
		if (arst_n && out_valid && !out_stall) begin
			got = '{distance, rank, valid_res, final_result};
			if (expected_words.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result word %h", got);
			end else begin
				exp_w = expected_words.pop_front();
				if (got !== exp_w) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected %h got %h", exp_w, got);
				end
			end
		end
	end

	// receiver stalls in random bursts
	always @(posedge clk) begin
		if (hold_long) out_stall <= 1;
		else if (quiet) out_stall <= 0;
		else if (stall_left > 0) begin
			out_stall <= 1;
			stall_left <= stall_left - 1;
		end else if (!out_stall && $urandom_range(0, 4) == 0) begin
			out_stall <= 1;
			stall_left <= $urandom_range(0, 2);
		end else out_stall <= 0;
	end

	stim_row_t rows[$];

	task automatic add_row(op_t o, logic [7:0] v, logic l, logic t, knn_res_t r);
		stim_row_t s;
		s.op = o; s.value = v; s.last = l; s.typed = t; s.res = r;
		rows = {rows, s};
	endtask

	initial begin
		int unsigned qn, kind;
		knn_res_t none, empty_res, zero_res;
		none = '0;
		empty_res = '{distance: 0, rank: 0, valid_res: 0, final_result: 1};
		zero_res = '{distance: 0, rank: 0, valid_res: 1, final_result: 1};
		q_len = 0; pos = 0; acc = 0; kept_n = 0; want = 1; mismatch = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed table
		add_row(OP_READ, 8'hff, 1, 1, empty_res);
		add_row(OP_POINT, 8'h12, 1, 0, none);
		add_row(OP_READ, 8'h00, 0, 1, empty_res);
		add_row(OP_QUERY, 8'h00, 0, 0, none);
		add_row(OP_QUERY, 8'hff, 1, 0, none);
		add_row(OP_POINT, 8'h00, 0, 0, none);
		add_row(OP_POINT, 8'hff, 1, 0, none);
		add_row(OP_READ, 8'h00, 0, 1, zero_res);
		add_row(OP_POINT, 8'hff, 0, 0, none);
		add_row(OP_POINT, 8'h00, 1, 0, none);
		add_row(OP_POINT, 8'h01, 0, 0, none);
		add_row(OP_NONE, 8'haa, 1, 0, none);
		add_row(OP_POINT, 8'h02, 0, 0, none);
		add_row(OP_POINT, 8'h03, 1, 0, none);
		add_row(OP_POINT, 8'h55, 1, 0, none);
		add_row(OP_READ, 8'h00, 0, 0, none);
		add_row(OP_READ, 8'h00, 0, 1, empty_res);
		foreach (rows[i]) begin
			send_word(rows[i].op, rows[i].value, rows[i].last);
			if (rows[i].typed && expected_words.size() != 0
					&& expected_words[$] !== rows[i].res) begin
				errors++;
				$display("table row %0d: predictor disagrees with typed result", i);
			end
		end
		go_idle();

		// full list with ties, long receiver hold-off
		write_limit(5'd16);
		send_query(2, 1);
		fork
			begin
				hold_long = 1;
				repeat (800) @(posedge clk);
				hold_long = 0;
			end
			begin
				for (int i = 0; i < 20; i++) begin
					send_word(OP_POINT, 8'(i % 3), 0);
					send_word(OP_POINT, 8'hff, 1);
				end
				send_word(OP_READ, 0, 0);
				send_word(OP_READ, 0, 0);
				in_valid <= 0;
			end
		join
		go_idle();

		// limit of zero acts as one
		write_limit(5'd0);
		send_query(3, 0);
		send_point(3);
		send_point(3);
		send_word(OP_READ, 0, 0);
		go_idle();

		// largest difference per element, limit above maximum
		write_limit(5'd31);
		send_query(4, 1);
		for (int i = 0; i < 4; i++)
			send_word(OP_POINT, (i % 2) ? 8'h00 : 8'hff, i == 3);
		send_point(4);
		send_word(OP_READ, 0, 0);
		go_idle();

		// random phases
		for (int ph = 0; ph < 4; ph++) begin
			write_limit(5'($urandom_range(1, 16)));
			qn = $urandom_range(1, 6);
			// close any vector left open so the query starts at element zero
			send_word(OP_POINT, 8'h00, 1);
			send_query(qn, 0);
			if (ph == 3) quiet = 1;
			for (int j = 0; j < 4; j++) begin
				kind = $urandom_range(0, 9);
				if (kind < 6) send_point(qn);
				else if (kind < 7) send_point($urandom_range(1, 8));
				else if (kind < 9) send_word(OP_READ, 8'($urandom), 1'($urandom));
				else send_word(op_t'($urandom_range(1, 3)), 8'($urandom), 1'($urandom));
				if (j == 1) begin
					// change the limit mid-list
					go_idle();
					write_limit(5'($urandom_range(1, 16)));
				end
			end
			send_word(OP_READ, 0, 0);
			go_idle();
		end
		write_limit(5'd1);

		if (errors == 0) $display("tb_brute_force_knn_euclidean OK");
		else $display("tb_brute_force_knn_euclidean NOT OK");
		$finish;
	end
endmodule

[filelist.f]
+incdir+sv
sv/knn_pkg.sv
sv/knn_sqrt.sv
sv/brute_force_knn_euclidean.sv
test/tb_brute_force_knn_euclidean.sv
